// ===== rtl/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// shared width constants and control/status types for the gcd block
// ----------------------------------------------------------------------------
package egcd_pkg;

    localparam int DATA_WIDTH  = 31;
    localparam int SHIFT_WIDTH = $clog2(DATA_WIDTH);

    typedef logic [DATA_WIDTH-1:0]  t_data;
    typedef logic [SHIFT_WIDTH-1:0] t_shift;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic capture;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic done;
    } t_sts;

endpackage

// ===== rtl/egcd_in_if.sv =====
// ----------------------------------------------------------------------------
// egcd_in_if
// operand channel: valid/ready handshake with two operands
// ----------------------------------------------------------------------------
interface egcd_in_if;

    logic                valid;
    logic                ready;
    egcd_pkg::t_data     first_operand;
    egcd_pkg::t_data     second_operand;

    modport source (output valid, output first_operand, output second_operand, input ready);
    modport sink   (input valid, input first_operand, input second_operand, output ready);

endinterface

// ===== rtl/egcd_out_if.sv =====
// ----------------------------------------------------------------------------
// egcd_out_if
// result channel: valid/ready handshake with the divisor
// ----------------------------------------------------------------------------
interface egcd_out_if;

    logic                valid;
    logic                ready;
    egcd_pkg::t_data     divisor;

    modport source (output valid, output divisor, input ready);
    modport sink   (input valid, input divisor, output ready);

endinterface

// ===== rtl/euclidean_gcd_top.sv =====
// ----------------------------------------------------------------------------
// euclidean_gcd_top
// greatest common divisor of two unsigned operands (binary gcd)
//
//   channel  dir  modport  payload
//   i_in     in   sink     first_operand, second_operand
//   o_out    out  source   divisor
//
// one item at a time: the operands are loaded, then the datapath steps until
// an operand is zero (each step drops at least one operand bit), then the result
// is captured. each step uses the single subtract-and-shift unit in egcd_dp.
// the result sits in an output register, so the next item is taken while it
// waits; a stalled output only holds the finished item before capture.
// reset is synchronous, active low, and clears the controller only.
// ----------------------------------------------------------------------------
module euclidean_gcd_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    egcd_in_if.sink    i_in,
    egcd_out_if.source o_out
);

    egcd_pkg::t_cmd w_cmd;
    egcd_pkg::t_sts w_sts;

    egcd_dp u_dp (
        .i_clk            (i_clk),
        .i_cmd            (w_cmd),
        .i_first_operand  (i_in.first_operand),
        .i_second_operand (i_in.second_operand),
        .o_sts            (w_sts),
        .o_divisor        (o_out.divisor)
    );

    egcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

endmodule

// ===== rtl/egcd_dp.sv =====
// ----------------------------------------------------------------------------
// egcd_dp
// binary gcd datapath: operand registers, common power-of-two count and
// result register
// ----------------------------------------------------------------------------
module egcd_dp (
    input  logic             i_clk,
    input  egcd_pkg::t_cmd   i_cmd,
    input  egcd_pkg::t_data  i_first_operand,
    input  egcd_pkg::t_data  i_second_operand,
    output egcd_pkg::t_sts   o_sts,
    output egcd_pkg::t_data  o_divisor
);

    egcd_pkg::t_data  r_a, n_a;
    egcd_pkg::t_data  r_b, n_b;
    egcd_pkg::t_shift r_k, n_k;
    egcd_pkg::t_data  r_div;
    egcd_pkg::t_data  w_diff;
    egcd_pkg::t_data  w_odd_part;
    logic             w_a_ge_b;

    assign w_a_ge_b = (r_a >= r_b);
    assign w_diff   = w_a_ge_b ? (r_a - r_b) : (r_b - r_a);

    // done once either operand reaches zero
    assign o_sts.done = (r_a == '0) || (r_b == '0);
    assign w_odd_part = (r_a == '0) ? r_b : r_a;
    assign o_divisor  = r_div;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        if (i_cmd.load) begin
            n_a = i_first_operand;
            n_b = i_second_operand;
            n_k = '0;
        end else if (i_cmd.step) begin
            if (!r_a[0] && !r_b[0]) begin
                // common factor of two
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (w_a_ge_b) begin
                // both odd: difference is even
                n_a = w_diff >> 1;
            end else begin
                n_b = w_diff >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_k <= n_k;
        if (i_cmd.capture) begin
            r_div <= w_odd_part << r_k;
        end
    end

endmodule

// ===== rtl/egcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// egcd_ctrl
// controller: accepts operands, steps the datapath until done, hands the
// result to the output register
// ----------------------------------------------------------------------------
module egcd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  egcd_pkg::t_sts  i_sts,
    output egcd_pkg::t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.step    = (r_state == ST_RUN) && !i_sts.done;
        o_cmd.capture = (r_state == ST_RUN) && i_sts.done && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (o_cmd.capture) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (o_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== verif/euclidean_gcd_top_tb.sv =====
// ----------------------------------------------------------------------------
// euclidean_gcd_top_tb
// self-checking bench for the gcd block: a directed table of corner operands,
// then random operand pairs of several shapes, each divisor checked in order
// against a hand-written value or a modulo-based euclid predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module euclidean_gcd_top_tb;

    typedef egcd_pkg::t_data t_data;

    localparam t_data MAX_OP      = {egcd_pkg::DATA_WIDTH{1'b1}};
    localparam t_data TOP_BIT     = t_data'(1) << (egcd_pkg::DATA_WIDTH - 1);
    localparam int    N_DIRECTED  = 21;
    localparam int    N_RANDOM    = 700;
    localparam int    DRAIN_CYCLES = 2 * egcd_pkg::DATA_WIDTH + 16;
    localparam int    IDLE_LIMIT  = 5000;

    typedef struct packed {
        logic  typed;      // divisor below is written out by hand
        t_data first_op;
        t_data second_op;
        t_data divisor;
    } t_gcd_case;

    t_gcd_case directed_cases [N_DIRECTED] = '{
        '{1'b1, t_data'(0),     t_data'(0),             t_data'(0)},
        '{1'b1, t_data'(0),     MAX_OP,                 MAX_OP},
        '{1'b1, MAX_OP,         t_data'(0),             MAX_OP},
        '{1'b1, MAX_OP,         MAX_OP,                 MAX_OP},
        '{1'b1, t_data'(1),     MAX_OP,                 t_data'(1)},
        '{1'b1, MAX_OP,         t_data'(1),             t_data'(1)},
        '{1'b1, MAX_OP,         MAX_OP - t_data'(1),    t_data'(1)},
        '{1'b1, TOP_BIT,        TOP_BIT >> 1,           TOP_BIT >> 1},
        '{1'b1, TOP_BIT,        t_data'(1),             t_data'(1)},
        '{1'b1, TOP_BIT,        TOP_BIT,                TOP_BIT},
        '{1'b1, t_data'(1),     t_data'(0),             t_data'(1)},
        '{1'b1, t_data'(0),     t_data'(1),             t_data'(1)},
        '{1'b1, t_data'(5),     t_data'(5),             t_data'(5)},
        '{1'b1, t_data'(0),     t_data'(31'h2AAA_AAAA), t_data'(31'h2AAA_AAAA)},
        // consecutive fibonacci numbers, the longest euclid chain in range
        '{1'b1, t_data'(31'd1836311903), t_data'(31'd1134903170), t_data'(1)},
        '{1'b0, t_data'(12),    t_data'(18),            t_data'(0)},
        '{1'b0, t_data'(31'h5555_5555), t_data'(31'h2AAA_AAAA), t_data'(0)},
        '{1'b0, MAX_OP - t_data'(1), TOP_BIT,           t_data'(0)},
        '{1'b0, t_data'(997 * 1009), t_data'(1009 * 1013), t_data'(0)},
        '{1'b0, t_data'(31'h7FFF_0000), t_data'(31'h0000_FFFF), t_data'(0)},
        '{1'b0, t_data'(31'h0123_4567), t_data'(31'h0765_4321), t_data'(0)}
    };

    logic i_clk;
    logic i_rst_n;

    egcd_in_if  in_ch ();
    egcd_out_if out_ch ();

    euclidean_gcd_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_data pending_divisors [$];
    int    mismatches;
    int    accepted_inputs;
    int    no_gap_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_data euclid_divisor(t_data a, t_data b);
        t_data x;
        t_data y;
        x = a;
        y = b;
        while (x != '0 && y != '0) begin
            if (x > y) begin
                x = x % y;
            end else begin
                y = y % x;
            end
        end
        return (x == '0) ? y : x;
    endfunction

    task automatic report_mismatch(string what, t_data got, t_data want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // holds the item on the channel until it is taken, then records its divisor
    task automatic send_operands(t_data a, t_data b, t_data want);
        in_ch.valid          <= 1'b1;
        in_ch.first_operand  <= a;
        in_ch.second_operand <= b;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        pending_divisors.push_back(want);
        accepted_inputs++;
    endtask

    task automatic idle_sender();
        int pick;
        int gap;
        pick = $urandom_range(0, 15);
        if (no_gap_left > 0) begin
            no_gap_left--;
            gap = 0;
        end else if (pick == 0) begin
            no_gap_left = $urandom_range(10, 40);
            gap = 0;
        end else if (pick < 9) begin
            gap = 0;
        end else if (pick < 15) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender stays quiet until every divisor in flight has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_divisors.size() != 0) @(posedge i_clk);
    endtask

    task automatic pick_operands(output t_data a, output t_data b);
        int shape;
        shape = $urandom_range(0, 9);
        case (shape)
            4: begin
                a = t_data'($urandom_range(0, 255));
                b = t_data'($urandom_range(0, 255));
            end
            5: begin
                // shared factor so the divisor is large
                a = t_data'($urandom_range(1, 65535));
                b = a * t_data'($urandom_range(0, 32767));
                a = a * t_data'($urandom_range(0, 32767));
            end
            6: begin
                a = t_data'($urandom << $urandom_range(0, egcd_pkg::DATA_WIDTH - 1));
                b = t_data'($urandom << $urandom_range(0, egcd_pkg::DATA_WIDTH - 1));
            end
            7: begin
                a = t_data'($urandom);
                b = '0;
                if ($urandom_range(0, 1) == 1) begin
                    b = a;
                    a = '0;
                end
            end
            8: begin
                a = t_data'($urandom);
                b = a;
            end
            9: begin
                a = t_data'($urandom_range(1, 1000));
                b = a * t_data'($urandom_range(1, 1000000));
            end
            default: begin
                a = t_data'($urandom);
                b = t_data'($urandom);
            end
        endcase
    endtask

    always @(posedge i_clk) begin : divisor_check
        t_data want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_divisors.size() == 0) begin
                report_mismatch("unexpected divisor", out_ch.divisor, '0);
            end else begin
                want = pending_divisors.pop_front();
                if (out_ch.divisor !== want) begin
                    report_mismatch("divisor", out_ch.divisor, want);
                end
            end
        end
    end

    initial begin : result_sink
        int run_left;
        bit run_ready;
        int hold_left;
        bit held;
        run_left  = 0;
        run_ready = 1'b0;
        hold_left = 0;
        held      = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            // one long hold-off so the block backs up and stalls its input
            if (!held && accepted_inputs >= 60) begin
                held      = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (run_left == 0) begin
                    run_ready = !run_ready;
                    if (run_ready) begin
                        run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                              : $urandom_range(1, 20);
                    end else begin
                        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                              : $urandom_range(1, 3);
                    end
                end
                run_left--;
                out_ch.ready <= run_ready;
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL euclidean_gcd_top");
        $finish;
    end

    initial begin : stimulus
        t_data a;
        t_data b;
        t_data want;
        mismatches      = 0;
        accepted_inputs = 0;
        no_gap_left     = 0;
        i_rst_n              = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.first_operand  = '0;
        in_ch.second_operand = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            a    = directed_cases[i].first_op;
            b    = directed_cases[i].second_op;
            want = directed_cases[i].typed ? directed_cases[i].divisor : euclid_divisor(a, b);
            send_operands(a, b, want);
            idle_sender();
        end
        drain_results();

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 2) begin
                drain_results();
            end
            pick_operands(a, b);
            send_operands(a, b, euclid_divisor(a, b));
            idle_sender();
        end

        in_ch.valid <= 1'b0;
        while (pending_divisors.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS euclidean_gcd_top");
        end else begin
            $display("FAIL euclidean_gcd_top");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/egcd_pkg.sv
rtl/egcd_in_if.sv
rtl/egcd_out_if.sv
rtl/egcd_dp.sv
rtl/egcd_ctrl.sv
rtl/euclidean_gcd_top.sv
verif/euclidean_gcd_top_tb.sv
